FILE: rtl/tkrs_pkg.sv
// Package for the top-k running sum block: word types, opcode and status codes,
// and the control and flag structs used between the top level and its cells.
// No dependencies.
`default_nettype none
package tkrs_pkg;

  localparam int VAL_W = 48;
  localparam int SUM_W = 64;
  localparam int KC_W  = 11;
  localparam int ST_W  = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [ST_W-1:0] STAT_DONE     = 2'd0;
  localparam logic [ST_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] STAT_FULL     = 2'd2;

  typedef struct packed {
    logic                    opcode;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] top_sum;
    logic [ST_W-1:0]         status;
    logic [KC_W-1:0]         entry_count;
  } out_word_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [VAL_W-1:0] x;
  } cell_cmd_t;

  // per-cell compare results against the broadcast value
  typedef struct packed {
    logic valid;
    logic ge;
    logic gt;
    logic eq;
  } cell_flag_t;

endpackage
`default_nettype wire

FILE: rtl/tkrs_cell.sv
// One entry of the descending sorted chain: holds a value and its valid bit,
// compares against the broadcast value and shifts from a neighbor. Uses tkrs_pkg.
`default_nettype none
module tkrs_cell (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire tkrs_pkg::cell_cmd_t           cmd_i,
  input  wire [tkrs_pkg::VAL_W-1:0]          prev_val_i,
  input  wire                                prev_valid_i,
  input  wire                                prev_ge_i,
  input  wire [tkrs_pkg::VAL_W-1:0]          next_val_i,
  input  wire                                next_valid_i,
  output logic [tkrs_pkg::VAL_W-1:0]         val_o,
  output tkrs_pkg::cell_flag_t               flag_o
);

  logic [tkrs_pkg::VAL_W-1:0] val_q, val_d;
  logic                       valid_q, valid_d;

  always_comb begin
    flag_o.valid = valid_q;
    flag_o.ge    = valid_q && ($signed(val_q) >= $signed(cmd_i.x));
    flag_o.gt    = valid_q && ($signed(val_q) > $signed(cmd_i.x));
    flag_o.eq    = valid_q && (val_q == cmd_i.x);
  end

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (cmd_i.ins && !flag_o.ge) begin
      val_d   = prev_ge_i ? cmd_i.x : prev_val_i;
      valid_d = prev_ge_i ? 1'b1 : prev_valid_i;
    end else if (cmd_i.del && !flag_o.gt) begin
      val_d   = next_val_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule
`default_nettype wire

FILE: rtl/top_k_running_sum.sv
// Top level of the top-k running sum block: the cell chain, boundary taps,
// running sum and handshakes. Uses tkrs_pkg and tkrs_cell.
//
// Values are held largest first in a chain of CAPACITY cells. An insert or
// delete shifts the chain while the entries at the top-group edge are tapped
// and registered; the sum is corrected from them in the sum state once the
// output can take the result, and a new word is taken as its result is written.
// A write of keep_count rebuilds the sum by stepping over the top group, a read
// state and an add state per entry, with input stalled meanwhile.
`default_nettype none
module top_k_running_sum #(
  parameter int CAPACITY = 1024
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire tkrs_pkg::in_word_t         in_word_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output tkrs_pkg::out_word_t             out_word_o,
  input  wire                             cfg_we_i,
  input  wire [tkrs_pkg::KC_W-1:0]        cfg_data_i
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int SELW  = ((IDX_W > tkrs_pkg::KC_W) ? IDX_W : tkrs_pkg::KC_W) + 1;
  localparam int VW    = tkrs_pkg::VAL_W;
  localparam int SW    = tkrs_pkg::SUM_W;
  localparam int KW    = tkrs_pkg::KC_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_RRD  = 3'd3;
  localparam logic [2:0] ST_RADD = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [KW-1:0]           keep_q;
  logic [KW-1:0]           k;
  logic [KW-1:0]           j_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [SW-1:0]    sum_q, sum_d;
  logic                    op_q;
  logic [VW-1:0]           x_q;
  logic                    commit_q;
  logic [tkrs_pkg::ST_W-1:0] status_q;
  logic [VW-1:0]           a_val_q, b_val_q, a_val, b_val;
  logic                    a_valid_q, b_valid_q, a_flag_q, a_valid, b_valid, a_flag;
  logic                    out_valid_q;
  tkrs_pkg::out_word_t     out_q;

  tkrs_pkg::cell_cmd_t     cmd;
  logic [VW-1:0]           vals [CAPACITY];
  tkrs_pkg::cell_flag_t    flags [CAPACITY];
  logic                    found, full, out_ok, accept;
  logic [SELW-1:0]         sel_a, sel_b;

  assign k      = (keep_q == '0) ? '0 : keep_q - 1'b1;
  assign full   = (cnt_q == CNT_W'(CAPACITY));
  assign out_ok = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) || (state_q == ST_SUM && out_ok));
  assign accept = in_valid_i && !in_stall_o;

  assign cmd.x   = x_q;
  assign cmd.ins = (state_q == ST_EXEC) && (op_q == tkrs_pkg::OP_INSERT) && !full;
  assign cmd.del = (state_q == ST_EXEC) && (op_q == tkrs_pkg::OP_DELETE) && found;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    tkrs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_val_i   ((g == 0) ? '0 : vals[(g == 0) ? 0 : g - 1]),
      .prev_valid_i ((g == 0) ? 1'b0 : flags[(g == 0) ? 0 : g - 1].valid),
      .prev_ge_i    ((g == 0) ? 1'b1 : flags[(g == 0) ? 0 : g - 1].ge),
      .next_val_i   ((g == CAPACITY - 1) ? '0 : vals[(g == CAPACITY - 1) ? g : g + 1]),
      .next_valid_i ((g == CAPACITY - 1) ? 1'b0
                                         : flags[(g == CAPACITY - 1) ? g : g + 1].valid),
      .val_o        (vals[g]),
      .flag_o       (flags[g])
    );
  end

  // edge taps: one-hot select across the chain
  assign sel_a = (state_q == ST_RRD) ? SELW'(j_q) : SELW'(k) - 1'b1;
  assign sel_b = SELW'(k);

  always_comb begin
    found   = 1'b0;
    a_val   = '0;
    a_valid = 1'b0;
    a_flag  = 1'b0;
    b_val   = '0;
    b_valid = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      found = found | flags[i].eq;
      if (SELW'(unsigned'(i)) == sel_a) begin
        a_val   = vals[i];
        a_valid = flags[i].valid;
        a_flag  = (op_q == tkrs_pkg::OP_INSERT) ? flags[i].ge : flags[i].gt;
      end
      if (SELW'(unsigned'(i)) == sel_b) begin
        b_val   = vals[i];
        b_valid = flags[i].valid;
      end
    end
  end

  always_comb begin
    sum_d = sum_q;
    if (commit_q && (k != '0) && !a_flag_q) begin
      if (op_q == tkrs_pkg::OP_INSERT) begin
        sum_d = sum_q + SW'($signed(x_q)) - (a_valid_q ? SW'($signed(a_val_q)) : '0);
      end else begin
        sum_d = sum_q - SW'($signed(x_q)) + (b_valid_q ? SW'($signed(b_val_q)) : '0);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_SUM;
      ST_SUM:  if (out_ok) state_d = accept ? ST_EXEC : ST_IDLE;
      ST_RRD:  state_d = ST_RADD;
      ST_RADD: state_d = (j_q + 1'b1 == k) ? ST_IDLE : ST_RRD;
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = (cfg_data_i <= KW'(1)) ? ST_IDLE : ST_RRD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      keep_q      <= KW'(1);
      j_q         <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      commit_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SUM && out_ok && !cfg_we_i) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        keep_q <= cfg_data_i;
        j_q    <= '0;
        sum_q  <= '0;
      end else begin
        case (state_q)
          ST_EXEC: begin
            commit_q <= cmd.ins || cmd.del;
            if (cmd.ins) cnt_q <= cnt_q + 1'b1;
            else if (cmd.del) cnt_q <= cnt_q - 1'b1;
          end
          ST_SUM: begin
            if (out_ok) begin
              sum_q <= sum_d;
            end
          end
          ST_RADD: begin
            if (a_valid_q) sum_q <= sum_q + SW'($signed(a_val_q));
            j_q <= j_q + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_word_i.opcode;
      x_q  <= in_word_i.value;
    end
    if (state_q == ST_EXEC || state_q == ST_RRD) begin
      a_val_q   <= a_val;
      a_valid_q <= a_valid;
      a_flag_q  <= a_flag;
      b_val_q   <= b_val;
      b_valid_q <= b_valid;
    end
    if (state_q == ST_EXEC) begin
      if (op_q == tkrs_pkg::OP_INSERT) begin
        status_q <= full ? tkrs_pkg::STAT_FULL : tkrs_pkg::STAT_DONE;
      end else begin
        status_q <= found ? tkrs_pkg::STAT_DONE : tkrs_pkg::STAT_NOT_FOUND;
      end
    end
    if (state_q == ST_SUM && out_ok) begin
      out_q.top_sum     <= sum_d;
      out_q.status      <= status_q;
      out_q.entry_count <= KW'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  result_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_SUM))
    else $error("result word without sum update");

  accept_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (state_q == ST_IDLE || state_q == ST_SUM))
    else $error("word taken while chain busy");

  status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.status == tkrs_pkg::STAT_DONE ||
                     out_word_o.status == tkrs_pkg::STAT_NOT_FOUND ||
                     out_word_o.status == tkrs_pkg::STAT_FULL))
    else $error("bad status code");

endmodule
`default_nettype wire
